// ===== hdl/pqnc_pkg.sv =====
// ============================================================================
// pqnc_pkg: shared types and constants of the nearest-center search
// Holds the command and register codes, the fixed field widths, the
// write transaction that is sent to each subspace bank and the state type.
// ============================================================================
package pqnc_pkg;

    // Fixed field widths.
    localparam int SUBCODE_W = 8;
    localparam int DIST_W    = 32;
    localparam int SUM_W     = 35;
    localparam int CFG_W     = 9;

    // Number of lanes in the adder tree; unused lanes add zero.
    localparam int LANES = 8;

    // Input commands; the fourth code does nothing.
    localparam logic [1:0] CMD_TABLE_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CENTER_WRITE = 2'd1;
    localparam logic [1:0] CMD_QUERY        = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SUBSPACES_USED = 1'b0;
    localparam logic CFG_CENTERS_USED   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [3:0] SUBSPACES_USED_RESET = 4'd8;
    localparam logic [8:0] CENTERS_USED_RESET   = 9'd256;

    // Write transaction for one subspace bank.
    typedef struct packed {
        logic                 tbl_we;
        logic                 ctr_we;
        logic [SUBCODE_W-1:0] first_code;
        logic [SUBCODE_W-1:0] second_code;
        logic [SUBCODE_W-1:0] center_index;
        logic [SUBCODE_W-1:0] center_code;
        logic [DIST_W-1:0]    table_distance;
    } pqnc_wr_t;

    // Query sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } pqnc_state_t;

endpackage

// ===== hdl/pq_nearest_center_search_top.sv =====
// ============================================================================
// pq_nearest_center_search_top: nearest cluster center by symmetric distance
// Scans the centers in use one per cycle, sums the subspace table distances
// through a registered adder tree and keeps the smallest sum.
// ============================================================================
// Table and center writes are taken back to back. A query scans the centers
// in use, drains the lookup pipeline and loads its result into the output
// register once it is free; no new transaction is taken until then. The single
// read port of each center memory yields one center per cycle.
// Reset clears the control state and loads the register defaults (8, 256);
// the memories are not cleared and hold undefined data until written.
module pq_nearest_center_search_top #(
    parameter int SUBSPACES   = 8,
    parameter int CODEWORDS   = 256,
    parameter int MAX_CENTERS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [pqnc_pkg::CFG_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         cmd,
    input  logic [2:0]                         subspace,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]     first_code,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]     second_code,
    input  logic [pqnc_pkg::DIST_W-1:0]        table_distance,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]     center_index,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]     center_code,
    input  logic [63:0]                        query_code,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pqnc_pkg::SUBCODE_W-1:0]     nearest_center,
    output logic [pqnc_pkg::SUM_W-1:0]         nearest_distance
);
    import pqnc_pkg::*;

    localparam int CTR_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int PIPE  = 5;

    // Configuration registers.
    logic [3:0] subspaces_used_reg;
    logic [8:0] centers_used_reg;

    // Query context.
    logic [63:0]      qcode_reg;
    logic [3:0]       ms_reg;
    logic [8:0]       ks_reg;
    logic [3:0]       ms_next;
    logic [8:0]       ks_next;
    logic [CTR_W-1:0] k_reg;

    // Sequencer.
    pqnc_state_t state_reg;
    pqnc_state_t state_next;
    logic        in_accept;
    logic        query_start;
    logic        issue;
    logic        issue_last;
    logic        out_load;

    // Pipeline tokens.
    logic [PIPE:1] v_reg;
    logic [PIPE:1] last_reg;

    // Adder tree.
    logic [DIST_W-1:0] lane [0:LANES-1];
    logic [DIST_W:0]   l1_reg [0:3];
    logic [DIST_W+1:0] l2_reg [0:1];
    logic [SUM_W-1:0]  sum_reg;

    // Running minimum.
    logic [CTR_W-1:0] cmp_k_reg;
    logic [CTR_W-1:0] best_k_reg;
    logic [SUM_W-1:0] best_d_reg;
    logic             take_new;

    // Output register.
    logic                 out_valid_reg;
    logic [SUBCODE_W-1:0] nearest_center_reg;
    logic [SUM_W-1:0]     nearest_distance_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subspaces_used_reg <= SUBSPACES_USED_RESET;
            centers_used_reg   <= CENTERS_USED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SUBSPACES_USED: subspaces_used_reg <= cfg_data[3:0];
                CFG_CENTERS_USED:   centers_used_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Register values are clamped to the supported range when a query starts.
    always_comb
    begin
        priority if (subspaces_used_reg == 4'd0)
            ms_next = 4'd1;
        else if (subspaces_used_reg > 4'(SUBSPACES))
            ms_next = 4'(SUBSPACES);
        else
            ms_next = subspaces_used_reg;

        priority if (centers_used_reg == 9'd0)
            ks_next = 9'd1;
        else if (centers_used_reg > 9'(MAX_CENTERS))
            ks_next = 9'(MAX_CENTERS);
        else
            ks_next = centers_used_reg;
    end

    assign in_accept   = in_valid && !in_stall;
    assign query_start = in_accept && (cmd == CMD_QUERY);
    assign issue_last  = (9'(k_reg) == ks_reg - 9'd1);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (v_reg[PIPE] && last_reg[PIPE])
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_SCAN:   issue    = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: out_load = !out_valid_reg || !out_stall;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            v_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (query_start)
                k_reg <= '0;
            else if (issue)
                k_reg <= k_reg + 1'b1;
            v_reg    <= {v_reg[PIPE-1:1], issue};
            last_reg <= {last_reg[PIPE-1:1], issue && issue_last};
        end
    end

    // Query context is captured with the query transaction.
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            qcode_reg <= query_code;
            ms_reg    <= ms_next;
            ks_reg    <= ks_next;
        end
    end

    // One bank per subspace; lanes beyond the subspace count add zero.
    for (genvar m = 0; m < LANES; m++)
    begin : g_lane
        if (m < SUBSPACES)
        begin : g_bank
            pqnc_wr_t wr;

            always_comb
            begin
                wr.tbl_we = in_accept && (cmd == CMD_TABLE_WRITE)
                         && (subspace == 3'(m))
                         && ({1'b0, first_code}  < 9'(CODEWORDS))
                         && ({1'b0, second_code} < 9'(CODEWORDS));
                wr.ctr_we = in_accept && (cmd == CMD_CENTER_WRITE)
                         && (subspace == 3'(m))
                         && ({1'b0, center_index} < 9'(MAX_CENTERS));
                wr.first_code     = first_code;
                wr.second_code    = second_code;
                wr.center_index   = center_index;
                wr.center_code    = center_code;
                wr.table_distance = table_distance;
            end

            pqnc_bank #(
                .CODEWORDS   (CODEWORDS),
                .MAX_CENTERS (MAX_CENTERS)
            ) u_bank (
                .clk           (clk),
                .wr            (wr),
                .rd_center     (SUBCODE_W'(k_reg)),
                .query_subcode (qcode_reg[8*m +: 8]),
                .lane_enable   (4'(m) < ms_reg),
                .contribution  (lane[m])
            );
        end
        else
        begin : g_pad
            assign lane[m] = '0;
        end
    end

    // Registered adder tree: eight lanes to one 35-bit sum in three stages.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            l1_reg[i] <= {1'b0, lane[2*i]} + {1'b0, lane[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l2_reg[i] <= {1'b0, l1_reg[2*i]} + {1'b0, l1_reg[2*i+1]};
        end
        sum_reg <= {1'b0, l2_reg[0]} + {1'b0, l2_reg[1]};
    end

    // The first center always wins; later ones only when strictly smaller.
    assign take_new = (cmp_k_reg == '0) || (sum_reg < best_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_k_reg <= '0;
        end
        else if (query_start)
        begin
            cmp_k_reg <= '0;
        end
        else if (v_reg[PIPE])
        begin
            cmp_k_reg <= cmp_k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[PIPE] && take_new)
        begin
            best_k_reg <= cmp_k_reg;
            best_d_reg <= sum_reg;
        end
    end

    // Output register holds the result transaction until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            nearest_center_reg   <= SUBCODE_W'(best_k_reg);
            nearest_distance_reg <= best_d_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_center   = nearest_center_reg;
    assign nearest_distance = nearest_distance_reg;

`ifndef ASSERT_OFF
    // The pipeline is empty whenever the block waits for a transaction.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (v_reg == '0))
        else $error("lookup pipeline busy while idle");

    // The last center of a scan reaches the compare only while draining.
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[PIPE] && last_reg[PIPE]) |-> (state_reg == ST_DRAIN))
        else $error("last center compared outside the drain phase");

    // A new result appears only after the finish phase.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finish phase");
`endif

endmodule

// ===== hdl/pqnc_bank.sv =====
// ============================================================================
// pqnc_bank: one subspace of the symmetric distance lookup
// Keeps the center subcodes and the codeword distance table of one subspace
// in two synchronous memories and returns one table distance per cycle.
// ============================================================================
module pqnc_bank #(
    parameter int CODEWORDS   = 256,
    parameter int MAX_CENTERS = 256
) (
    input  logic                             clk,
    input  pqnc_pkg::pqnc_wr_t               wr,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]   rd_center,
    input  logic [pqnc_pkg::SUBCODE_W-1:0]   query_subcode,
    input  logic                             lane_enable,
    output logic [pqnc_pkg::DIST_W-1:0]      contribution
);
    import pqnc_pkg::*;

    localparam int CW_W  = $clog2(CODEWORDS);
    localparam int CTR_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

    logic [SUBCODE_W-1:0] center_mem [0:MAX_CENTERS-1];
    logic [DIST_W-1:0]    table_mem  [0:CODEWORDS-1][0:CODEWORDS-1];

    logic [SUBCODE_W-1:0] center_code_reg;
    logic [DIST_W-1:0]    table_data_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic [CW_W-1:0]      row;
    logic [CW_W-1:0]      col;

    // Center subcode memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.ctr_we)
        begin
            center_mem[wr.center_index[CTR_W-1:0]] <= wr.center_code;
        end
        center_code_reg <= center_mem[rd_center[CTR_W-1:0]];
    end

    // The table is addressed by the query subcode and the stored center subcode.
    assign row = query_subcode[CW_W-1:0];
    assign col = center_code_reg[CW_W-1:0];

    // A lookup counts only in an enabled lane with both subcodes in range.
    always_comb
    begin
        hit_next = lane_enable
                && ({1'b0, query_subcode} < 9'(CODEWORDS))
                && ({1'b0, center_code_reg} < 9'(CODEWORDS));
    end

    // Distance table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.tbl_we)
        begin
            table_mem[wr.first_code[CW_W-1:0]][wr.second_code[CW_W-1:0]] <=
                wr.table_distance;
        end
        table_data_reg <= table_mem[row][col];
        hit_reg        <= hit_next;
    end

    // Lookups that miss add zero to the sum.
    assign contribution = hit_reg ? table_data_reg : '0;

endmodule
